### src/rws_pkg.sv
// Package for the repeat write splitter: field widths, mode register bit
// positions, state codes and the access width normalising function.
// No dependencies.
package rws_pkg;

  localparam int ADDR_W  = 26;
  localparam int BYTES_W = 4;
  localparam int DATA_W  = 64;
  localparam int MODE_W  = 9;
  localparam int REM_W   = 8;
  localparam int CNT_W   = 5;

  localparam logic [ADDR_W-1:0]  REG_SPACE_BASE = 26'h3f0_0000;
  localparam int                 ARM_BIT        = 7;
  localparam int                 PASS_BIT       = 8;
  localparam int                 ROW_BITS       = 11;
  localparam logic [CNT_W-1:0]   MAX_CMD_LAST   = 5'd23;

  localparam logic               OP_MODE  = 1'b0;
  localparam logic               OP_WRITE = 1'b1;

  localparam logic [1:0]         ST_IDLE = 2'd0;
  localparam logic [1:0]         ST_PREP = 2'd1;
  localparam logic [1:0]         ST_RUN  = 2'd2;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [DATA_W-1:0]  data_t;

  // Any access size other than 1, 2 or 8 bytes is handled as 4 bytes.
  function automatic bytes_t norm_width(input bytes_t w);
    bytes_t r;
    case (w)
      4'd1: r = 4'd1;
      4'd2: r = 4'd2;
      4'd8: r = 4'd8;
      default: r = 4'd4;
    endcase
    return r;
  endfunction

endpackage

### src/repeat_write_splitter_unit.sv
// Repeat write splitter top level: mode register, repeat sequencer and the
// registered command output. Depends on rws_pkg.
// A mode request or a request to register space gives no command. An unarmed
// write is loaded into the output register on acceptance. An armed write passes
// through a set-up state, then the sequencer emits one command per cycle while
// the output is not stalled (at most 24), and no new request is taken until the
// last command has been emitted. Reset clears the mode register, the sequencer
// and the output valid.
module repeat_write_splitter_unit #(
  parameter int MEMORY_BYTES = 8388608
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [8:0]               in_mode_value,
  input  logic [25:0]              in_address,
  input  logic [3:0]               in_width_bytes,
  input  logic [63:0]              in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [25:0]              out_write_address,
  output logic [3:0]               out_write_bytes,
  output logic [63:0]              out_write_data,
  output logic                     out_pass_flag,
  output logic                     out_last
);
  // A new request is taken only while the sequencer is idle and the output
  // register is empty or being emptied.

  localparam logic [26:0] MEM_END = 27'(MEMORY_BYTES);

  logic [1:0]                    state_r, state_nxt;
  logic [rws_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  rws_pkg::addr_t                phys_r, phys_nxt;
  rws_pkg::bytes_t               width_r, width_nxt;
  rws_pkg::data_t                value_r, value_nxt;
  logic [rws_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [rws_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  rws_pkg::addr_t                out_addr_r, out_addr_nxt;
  rws_pkg::bytes_t               out_bytes_r, out_bytes_nxt;
  rws_pkg::data_t                out_data_r, out_data_nxt;
  logic                          out_pass_r, out_pass_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          out_free;
  logic                          in_fire;
  rws_pkg::bytes_t               in_width_n;
  rws_pkg::data_t                unarmed_data;
  logic [7:0]                    len;
  logic [26:0]                   span_end;
  logic [26:0]                   span_end_cut;
  logic [31:0]                   pat;
  rws_pkg::bytes_t               step;
  rws_pkg::data_t                step_data;
  rws_pkg::data_t                step_value;
  logic [rws_pkg::REM_W-1:0]     rem_left;
  logic [rws_pkg::ROW_BITS-1:0]  row_next;
  logic                          step_last;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == rws_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign in_width_n = rws_pkg::norm_width(in_width_bytes);

  always_comb begin
    case (in_width_n)
      4'd1:    unarmed_data = {56'd0, in_data[7:0]};
      4'd2:    unarmed_data = {48'd0, in_data[15:0]};
      4'd8:    unarmed_data = in_data;
      default: unarmed_data = {32'd0, in_data[31:0]};
    endcase
  end

  // Span end is the 8-byte aligned address plus the repeat length, cut at
  // the end of memory.
  assign len          = {1'b0, mode_r[6:0]} + 8'd1;
  assign span_end     = {1'b0, phys_r[25:3], 3'b000} + 27'(len);
  assign span_end_cut = (span_end > MEM_END) ? MEM_END : span_end;

  // Narrow writes are masked according to the byte lane and rotated before
  // being doubled into a 64-bit pattern.
  always_comb begin
    pat = value_r[31:0];
    case (width_r)
      4'd1: begin
        case (phys_r[1:0])
          2'd0:    pat = {24'd0, value_r[7:0]};
          2'd1:    pat = {16'd0, value_r[15:0]};
          2'd2:    pat = {8'd0, value_r[23:0]};
          default: pat = value_r[31:0];
        endcase
        pat = {pat[7:0], pat[31:8]};
      end
      4'd2: begin
        pat = phys_r[1] ? value_r[31:0] : {16'd0, value_r[15:0]};
        pat = {pat[15:0], pat[31:16]};
      end
      default: pat = value_r[31:0];
    endcase
  end

  // Largest naturally aligned size that still fits in what is left.
  always_comb begin
    if (phys_r[2:0] == 3'd0 && rem_r >= 8'd8) begin
      step = 4'd8;
    end else if (phys_r[1:0] == 2'd0 && rem_r >= 8'd4) begin
      step = 4'd4;
    end else if (phys_r[0] == 1'b0 && rem_r >= 8'd2) begin
      step = 4'd2;
    end else begin
      step = 4'd1;
    end
  end

  always_comb begin
    case (step)
      4'd8: begin
        step_data  = value_r;
        step_value = value_r;
      end
      4'd4: begin
        step_data  = {32'd0, value_r[63:32]};
        step_value = {value_r[31:0], value_r[63:32]};
      end
      4'd2: begin
        step_data  = {48'd0, value_r[63:48]};
        step_value = {value_r[47:0], value_r[63:48]};
      end
      default: begin
        step_data  = {56'd0, value_r[63:56]};
        step_value = {value_r[55:0], value_r[63:56]};
      end
    endcase
  end

  assign rem_left  = rem_r - {4'd0, step};
  assign row_next  = phys_r[rws_pkg::ROW_BITS-1:0] + {7'd0, step};
  assign step_last = (rem_left == '0) || (cnt_r == rws_pkg::MAX_CMD_LAST);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    phys_nxt      = phys_r;
    width_nxt     = width_r;
    value_nxt     = value_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_bytes_nxt = out_bytes_r;
    out_data_nxt  = out_data_r;
    out_pass_nxt  = out_pass_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      rws_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == rws_pkg::OP_MODE) begin
            mode_nxt = in_mode_value;
          end else begin
            mode_nxt[rws_pkg::ARM_BIT] = 1'b0;
            if (in_address < rws_pkg::REG_SPACE_BASE) begin
              if (!mode_r[rws_pkg::ARM_BIT]) begin
                out_valid_nxt = 1'b1;
                out_addr_nxt  = in_address;
                out_bytes_nxt = in_width_n;
                out_data_nxt  = unarmed_data;
                out_pass_nxt  = mode_r[rws_pkg::PASS_BIT];
                out_last_nxt  = 1'b1;
              end else begin
                phys_nxt  = in_address;
                width_nxt = in_width_n;
                value_nxt = in_data;
                state_nxt = rws_pkg::ST_PREP;
              end
            end
          end
        end
      end
      rws_pkg::ST_PREP: begin
        if (span_end_cut <= {1'b0, phys_r}) begin
          state_nxt = rws_pkg::ST_IDLE;
        end else begin
          rem_nxt   = rws_pkg::REM_W'(span_end_cut - {1'b0, phys_r});
          cnt_nxt   = '0;
          if (width_r != 4'd8) begin
            value_nxt = {pat, pat};
          end
          state_nxt = rws_pkg::ST_RUN;
        end
      end
      rws_pkg::ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = phys_r;
          out_bytes_nxt = step;
          out_data_nxt  = step_data;
          out_pass_nxt  = 1'b0;
          out_last_nxt  = step_last;
          value_nxt     = step_value;
          phys_nxt      = {phys_r[rws_pkg::ADDR_W-1:rws_pkg::ROW_BITS], row_next};
          rem_nxt       = rem_left;
          cnt_nxt       = cnt_r + 5'd1;
          if (step_last) begin
            state_nxt = rws_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = rws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rws_pkg::ST_IDLE;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phys_r      <= phys_nxt;
    width_r     <= width_nxt;
    value_r     <= value_nxt;
    out_addr_r  <= out_addr_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_data_r  <= out_data_nxt;
    out_pass_r  <= out_pass_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_bytes   = out_bytes_r;
  assign out_write_data    = out_data_r;
  assign out_pass_flag     = out_pass_r;
  assign out_last          = out_last_r;

  // Any write request leaves the repeat mode disarmed.
  a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == rws_pkg::OP_WRITE) |=> !mode_r[rws_pkg::ARM_BIT])
    else $error("arm bit still set after a write request");

  // The sequencer never runs with nothing left to cover.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_RUN) |-> (rem_r != '0))
    else $error("repeat sequencer running with an empty span");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_RUN) |-> (cnt_r <= rws_pkg::MAX_CMD_LAST))
    else $error("repeat command count exceeded");

  // Repeat commands are naturally aligned and carry no pass flag.
  a_repeat_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_RUN && out_free) |=>
      (out_valid_r && !out_pass_r &&
       ((out_addr_r[2:0] & 3'(out_bytes_r - 4'd1)) == 3'd0)))
    else $error("repeat command misaligned or flagged");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for repeat_write_splitter_unit: mode loads, plain and repeat
// writes, checked command by command against a predictor kept in a scoreboard class.
// Depends on rws_pkg and the repeat_write_splitter_unit RTL.

typedef struct packed {
  rws_pkg::addr_t  addr;
  rws_pkg::bytes_t nbytes;
  rws_pkg::data_t  data;
  logic            pass;
  logic            last;
} write_cmd_t;

class write_cmd_board;
  logic [rws_pkg::MODE_W-1:0] mode_reg;
  write_cmd_t                 expected_cmds[$];
  int unsigned                error_count;
  int                         mem_bytes;

  function new(int mem_size);
    mode_reg    = '0;
    error_count = 0;
    mem_bytes   = mem_size;
  endfunction

  function int pending();
    return expected_cmds.size();
  endfunction

  // Works out the commands that one accepted request causes.
  function void note_request(logic op, logic [rws_pkg::MODE_W-1:0] mode_in,
                             rws_pkg::addr_t addr, rws_pkg::bytes_t width_in,
                             rws_pkg::data_t data_in);
    logic           armed;
    int             w;
    int             len;
    int             span_end;
    int             remaining;
    int             cur;
    int             row_base;
    int             t;
    int             shift;
    int             n;
    logic [31:0]    pat;
    rws_pkg::data_t value;
    write_cmd_t     cmd;
    if (op == rws_pkg::OP_MODE) begin
      mode_reg = mode_in;
      return;
    end
    armed = mode_reg[rws_pkg::ARM_BIT];
    mode_reg[rws_pkg::ARM_BIT] = 1'b0;
    if (addr >= rws_pkg::REG_SPACE_BASE)
      return;
    if (width_in == 4'd1 || width_in == 4'd2 || width_in == 4'd8)
      w = int'(width_in);
    else
      w = 4;
    if (!armed) begin
      cmd.addr   = addr;
      cmd.nbytes = rws_pkg::bytes_t'(w);
      cmd.data   = (w == 8) ? data_in : data_in & ((64'd1 << (w * 8)) - 64'd1);
      cmd.pass   = mode_reg[rws_pkg::PASS_BIT];
      cmd.last   = 1'b1;
      expected_cmds.push_back(cmd);
      return;
    end
    len      = int'(mode_reg[rws_pkg::ARM_BIT-1:0]) + 1;
    cur      = int'(addr);
    span_end = (cur & ~7) + len;
    if (span_end > mem_bytes)
      span_end = mem_bytes;
    if (span_end <= cur)
      return;
    remaining = span_end - cur;
    // Narrow writes are widened into a 32-bit pattern, then doubled up to 64 bits.
    if (w != 8) begin
      pat = data_in[31:0];
      if (w == 1) begin
        pat = pat & (32'hffff_ffff >> (24 - 8 * int'(addr[1:0])));
        pat = {pat[7:0], pat[31:8]};
      end else if (w == 2) begin
        pat = pat & (32'hffff_ffff >> (16 - 16 * int'(addr[1])));
        pat = {pat[15:0], pat[31:16]};
      end
      value = {pat, pat};
    end else begin
      value = data_in;
    end
    row_base = cur & ~((1 << rws_pkg::ROW_BITS) - 1);
    n = 0;
    while (remaining != 0 && n < 24) begin
      t = 8;
      while (t > remaining || (cur % t) != 0)
        t = t / 2;
      cmd.addr   = rws_pkg::addr_t'(cur);
      cmd.nbytes = rws_pkg::bytes_t'(t);
      cmd.data   = value >> ((8 - t) * 8);
      cmd.pass   = 1'b0;
      cmd.last   = (remaining == t) || (n == 23);
      expected_cmds.push_back(cmd);
      n++;
      // An 8-byte step rotates by a whole word, which leaves the pattern as it is.
      shift = (t * 8) % 64;
      if (shift != 0)
        value = (value << shift) | (value >> (64 - shift));
      cur = row_base | ((cur + t) & ((1 << rws_pkg::ROW_BITS) - 1));
      remaining -= t;
    end
  endfunction

  function void report(string what, write_cmd_t want, write_cmd_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: expected addr %h bytes %0d data %h pass %b last %b",
               $time, what, want.addr, want.nbytes, want.data, want.pass, want.last);
      $display("%0t %s: got      addr %h bytes %0d data %h pass %b last %b",
               $time, what, got.addr, got.nbytes, got.data, got.pass, got.last);
    end
  endfunction

  function void check_command(write_cmd_t got);
    write_cmd_t want;
    if (expected_cmds.size() == 0) begin
      report("command with none expected", '0, got);
      return;
    end
    want = expected_cmds.pop_front();
    if (got.addr !== want.addr || got.nbytes !== want.nbytes || got.data !== want.data ||
        got.pass !== want.pass || got.last !== want.last)
      report("command mismatch", want, got);
  endfunction
endclass

module testbench;
  localparam int MEM_BYTES    = 8388608;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_ITEMS  = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [8:0]  in_mode_value = '0;
  logic [25:0] in_address = '0;
  logic [3:0]  in_width_bytes = '0;
  logic [63:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [25:0] out_write_address;
  logic [3:0]  out_write_bytes;
  logic [63:0] out_write_data;
  logic        out_pass_flag;
  logic        out_last;

  write_cmd_board board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  repeat_write_splitter_unit #(
    .MEMORY_BYTES(MEM_BYTES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_mode_value     (in_mode_value),
    .in_address        (in_address),
    .in_width_bytes    (in_width_bytes),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_bytes   (out_write_bytes),
    .out_write_data    (out_write_data),
    .out_pass_flag     (out_pass_flag),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: checks each accepted command, then decides whether to stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_command({out_write_address, out_write_bytes, out_write_data,
                           out_pass_flag, out_last});
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic rws_pkg::addr_t random_address();
    int             pick;
    rws_pkg::addr_t a;
    pick = $urandom_range(9);
    case (pick)
      6: a = rws_pkg::addr_t'(($urandom_range(MEM_BYTES - 1) & ~32'h7ff) |
                              (32'h7f0 + $urandom_range(15)));
      7: a = rws_pkg::addr_t'(MEM_BYTES - $urandom_range(1, 140));
      8: a = rws_pkg::addr_t'($urandom_range(32'h3ef_ffff));
      9: a = rws_pkg::addr_t'(rws_pkg::REG_SPACE_BASE + $urandom_range(32'hf_ffff));
      default: a = rws_pkg::addr_t'($urandom_range(MEM_BYTES - 1));
    endcase
    return a;
  endfunction

  function automatic rws_pkg::bytes_t random_width();
    rws_pkg::bytes_t w;
    if ($urandom_range(3) == 0)
      w = rws_pkg::bytes_t'($urandom_range(15));
    else
      w = 4'd1 << $urandom_range(3);
    return w;
  endfunction

  function automatic rws_pkg::data_t random_data();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(logic op, logic [8:0] mode, rws_pkg::addr_t addr,
                              rws_pkg::bytes_t width, rws_pkg::data_t data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_mode_value  <= mode;
    in_address     <= addr;
    in_width_bytes <= width;
    in_data        <= data;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    board.note_request(op, mode, addr, width, data);
    requests_sent++;
  endtask

  task automatic load_mode(logic [8:0] mode);
    send_request(rws_pkg::OP_MODE, mode, random_address(), random_width(), random_data());
  endtask

  task automatic write_request(rws_pkg::addr_t addr, rws_pkg::bytes_t width,
                               rws_pkg::data_t data);
    logic [8:0] junk;
    junk = 9'($urandom_range(511));
    send_request(rws_pkg::OP_WRITE, junk, addr, width, data);
  endtask

  // Mostly armed mode loads followed by a write, mixed with plain writes and stray
  // mode loads.
  task automatic random_requests(int goal);
    int         stop_at;
    int         pick;
    logic [8:0] mode;
    stop_at = requests_sent + goal;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        mode = 9'($urandom_range(511));
        mode[rws_pkg::ARM_BIT] = 1'b1;
        load_mode(mode);
        write_request(random_address(), random_width(), random_data());
      end else if (pick < 82) begin
        write_request(random_address(), random_width(), random_data());
      end else begin
        load_mode(9'($urandom_range(511)));
      end
    end
  endtask

  initial begin
    board = new(MEM_BYTES);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Plain writes, first with the mode register still clear, then with the pass flag set.
    write_request(26'h000_0000, 4'd1, '1);
    write_request(26'h3ef_ffff, 4'd8, '1);
    write_request(rws_pkg::REG_SPACE_BASE, 4'd2, random_data());
    write_request(26'h012_3456, 4'd0, random_data());
    load_mode(9'h100);
    write_request(26'h000_4002, 4'd2, '1);
    // Full mode value: pass flag, armed, longest repeat.
    load_mode(9'h1ff);
    write_request(26'h000_0800, 4'd8, random_data());
    write_request(26'h000_0800, 4'd8, random_data());
    // Repeat span that ends before the write address.
    load_mode(9'h080);
    write_request(26'h000_0105, 4'd1, random_data());
    // Repeat cut at the end of memory, and wholly beyond it.
    load_mode(9'h0ff);
    write_request(rws_pkg::addr_t'(MEM_BYTES - 3), 4'd1, random_data());
    load_mode(9'h0ff);
    write_request(26'h090_0000, 4'd4, random_data());
    // A register space write still disarms the repeat.
    load_mode(9'h0ff);
    write_request(rws_pkg::REG_SPACE_BASE + 26'h10, 4'd4, random_data());
    write_request(26'h000_0040, 4'd4, random_data());
    // Repeat that wraps round within its row, and narrow unaligned patterns.
    load_mode(9'h0c7);
    write_request(26'h000_07fb, 4'd2, random_data());
    load_mode(9'h09f);
    write_request(26'h000_1003, 4'd1, random_data());
    load_mode(9'h0ff);
    write_request(26'h000_2001, 4'd1, random_data());

    // The receiver holds off for a long stretch while requests keep coming.
    hold_requests <= hold_requests + 1;
    random_requests(PHASE_ITEMS);
    send_idle_pct = 52;
    random_requests(PHASE_ITEMS);
    send_idle_pct = 0;
    stall_pct <= 52;
    random_requests(PHASE_ITEMS);
    send_idle_pct = 17;
    stall_pct <= 17;
    random_requests(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule

### sim.f
src/rws_pkg.sv
src/repeat_write_splitter_unit.sv
tb/testbench.sv
